>>> rtl/npcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and controller encodings for the nearest palette color search.
package npcs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int CHAN_W          = 8;
  localparam int NUM_CHAN        = 4;
  localparam int WORD_W          = CHAN_W * NUM_CHAN;
  localparam int SIZE_W          = 9;
  localparam int SLOT_W          = 8;
  localparam int DIST_W          = 18;
  localparam int SQ_W            = 2 * CHAN_W;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/npcs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module npcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/npcs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences palette loads and pixel searches.
module npcs_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    req_type_i,
  output logic                    in_stall_o,
  input  npcs_pkg::dp_status_t    status_i,
  output npcs_pkg::dp_cmd_t       cmd_o
);

  npcs_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i && (state_q == npcs_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npcs_pkg::ST_IDLE: begin
        if (accept && (req_type_i == npcs_pkg::REQ_PIXEL)) begin
          state_d = npcs_pkg::ST_SEARCH;
        end
      end
      npcs_pkg::ST_SEARCH: begin
        if (status_i.last_addr) begin
          state_d = npcs_pkg::ST_DRAIN;
        end
      end
      npcs_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          state_d = npcs_pkg::ST_IDLE;
        end
      end
      default: state_d = npcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      npcs_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = accept && (req_type_i == npcs_pkg::REQ_LOAD);
        cmd_o.start = accept && (req_type_i == npcs_pkg::REQ_PIXEL);
      end
      npcs_pkg::ST_SEARCH: begin
        cmd_o.rd_en = 1'b1;
      end
      npcs_pkg::ST_DRAIN: begin
        cmd_o.out_load = !status_i.pipe_busy && status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/npcs_dp.sv
`timescale 1ns / 1ps
// Datapath with palette store, distance pipeline, running minimum and output register.
module npcs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  npcs_pkg::dp_cmd_t                   cmd_i,
  output npcs_pkg::dp_status_t                status_o,
  input  logic [npcs_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         red_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         green_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         blue_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         alpha_i,
  input  logic                                cfg_write_i,
  input  logic [npcs_pkg::SIZE_W-1:0]         cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [npcs_pkg::SLOT_W-1:0]         palette_index_o,
  output logic [npcs_pkg::DIST_W-1:0]         best_distance_o
);

  localparam int IDX_W  = npcs_pkg::IDX_W;
  localparam int CHAN_W = npcs_pkg::CHAN_W;
  localparam int NCH    = npcs_pkg::NUM_CHAN;
  localparam int SQ_W   = npcs_pkg::SQ_W;
  localparam int DIST_W = npcs_pkg::DIST_W;
  localparam logic [npcs_pkg::SIZE_W-1:0] ENTRIES_SZ =
    npcs_pkg::SIZE_W'(npcs_pkg::PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(npcs_pkg::PALETTE_ENTRIES - 1);

  logic [IDX_W-1:0]                last_q, last_d;
  logic [IDX_W-1:0]                addr_q;
  logic                            valid1_q, valid2_q;
  logic [IDX_W-1:0]                idx1_q, idx2_q;
  logic [NCH-1:0][CHAN_W-1:0]      pix_q;
  logic [NCH-1:0][SQ_W-1:0]        sq_q, sq_d;
  logic [DIST_W-1:0]               dist_sum;
  logic [DIST_W-1:0]               best_q;
  logic [IDX_W-1:0]                bidx_q;
  logic                            out_valid_q;
  logic [npcs_pkg::SLOT_W-1:0]     out_idx_q;
  logic [DIST_W-1:0]               out_dist_q;
  logic [npcs_pkg::WORD_W-1:0]     rdata;
  logic                            slot_ok;
  logic                            out_free;

  assign slot_ok = {1'b0, entry_index_i} < ENTRIES_SZ;

  npcs_ram #(
    .WIDTH(npcs_pkg::WORD_W),
    .DEPTH(npcs_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && slot_ok),
    .waddr_i(entry_index_i[IDX_W-1:0]),
    .wdata_i({alpha_i, blue_i, green_i, red_i}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    if (cfg_data_i == '0) begin
      last_d = '0;
    end else if (cfg_data_i > ENTRIES_SZ) begin
      last_d = LAST_MAX;
    end else begin
      last_d = IDX_W'(cfg_data_i - npcs_pkg::SIZE_W'(1));
    end
  end

  always_comb begin
    logic [CHAN_W-1:0] a, b, d;
    for (int c = 0; c < NCH; c++) begin
      a = pix_q[c];
      b = rdata[c*CHAN_W +: CHAN_W];
      d = (a >= b) ? (a - b) : (b - a);
      sq_d[c] = SQ_W'(d) * SQ_W'(d);
    end
  end

  assign dist_sum = DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2])
                  + DIST_W'(sq_q[3]);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= LAST_MAX;
      addr_q      <= '0;
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        last_q <= last_d;
      end
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.rd_en) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      valid1_q <= cmd_i.rd_en;
      valid2_q <= valid1_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_q  <= {alpha_i, blue_i, green_i, red_i};
      best_q <= '1;
      bidx_q <= '0;
    end else if (valid2_q && (dist_sum <= best_q)) begin
      best_q <= dist_sum;
      bidx_q <= idx2_q;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    sq_q   <= sq_d;
    if (cmd_i.out_load) begin
      out_idx_q  <= npcs_pkg::SLOT_W'(bidx_q);
      out_dist_q <= best_q;
    end
  end

  assign status_o.last_addr = (addr_q == last_q);
  assign status_o.pipe_busy = valid1_q || valid2_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = out_idx_q;
  assign best_distance_o = out_dist_q;

endmodule

>>> rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Top level of the nearest palette color search: controller and datapath.
//
//   Channel  Direction  Handshake             Word
//   in       slave      in_valid_i/in_stall_o  req_type, entry_index, red, green, blue, alpha
//   out      master     out_valid_o/out_stall_i palette_index, best_distance
//   cfg      slave      cfg_valid_i/cfg_ready_o palette_size
//
// A load word writes the palette RAM directly.
// A pixel word searches N entries: the search walks the
// palette RAM read port one entry per cycle, then drains a three-stage pipeline.
// A stalled result waits in the output register while the next word is accepted;
// a finished search holds until that register is free.
// Reset sets palette_size to 256; the palette RAM holds nothing until loaded.
module nearest_palette_color_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [npcs_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         red_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         green_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         blue_i,
  input  logic [npcs_pkg::CHAN_W-1:0]         alpha_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [npcs_pkg::SLOT_W-1:0]         palette_index_o,
  output logic [npcs_pkg::DIST_W-1:0]         best_distance_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [npcs_pkg::SIZE_W-1:0]         cfg_data_i
);

  npcs_pkg::dp_cmd_t    cmd;
  npcs_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  npcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_type_i(req_type_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  npcs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .palette_index_o(palette_index_o),
    .best_distance_o(best_distance_o)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest palette color search: random palettes and pixels over a fixed list of sizes.
module tb_top;

  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 2000;
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    npcs_pkg::req_e              kind;
    logic [npcs_pkg::SLOT_W-1:0] slot;
    logic [npcs_pkg::WORD_W-1:0] color;
  } color_req_t;

  typedef struct packed {
    logic [npcs_pkg::SLOT_W-1:0] idx;
    logic [npcs_pkg::DIST_W-1:0] distance;
  } nearest_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic                          req_type_i    = 1'b0;
  logic [npcs_pkg::SLOT_W-1:0]   entry_index_i = '0;
  logic [npcs_pkg::CHAN_W-1:0]   red_i         = '0;
  logic [npcs_pkg::CHAN_W-1:0]   green_i       = '0;
  logic [npcs_pkg::CHAN_W-1:0]   blue_i        = '0;
  logic [npcs_pkg::CHAN_W-1:0]   alpha_i       = '0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [npcs_pkg::SLOT_W-1:0]   palette_index_o;
  logic [npcs_pkg::DIST_W-1:0]   best_distance_o;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [npcs_pkg::SIZE_W-1:0]   cfg_data_i    = '0;

  color_req_t                    req_q[$];
  nearest_t                      nearest_q[$];
  logic [npcs_pkg::WORD_W-1:0]   mdl_pal[npcs_pkg::PALETTE_ENTRIES];
  logic [npcs_pkg::SIZE_W-1:0]   mdl_size      =
    npcs_pkg::SIZE_W'(npcs_pkg::PALETTE_ENTRIES);
  logic [npcs_pkg::WORD_W-1:0]   plan_pal[npcs_pkg::PALETTE_ENTRIES];
  logic                          in_fire       = 1'b0;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;
  logic                          hold_req      = 1'b0;
  logic                          hold_seen     = 1'b0;
  int                            hold_left     = 0;
  int                            error_cnt     = 0;
  int                            cycle_cnt     = 0;
  int                            phase_cnt     = 0;

  nearest_palette_color_search uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .palette_index_o(palette_index_o),
    .best_distance_o(best_distance_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_mismatch(input string msg);
    error_cnt++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned searched(input logic [npcs_pkg::SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > npcs_pkg::PALETTE_ENTRIES) return npcs_pkg::PALETTE_ENTRIES;
    return 32'(size);
  endfunction

  function automatic int unsigned sq_diff(input logic [npcs_pkg::CHAN_W-1:0] x,
                                          input logic [npcs_pkg::CHAN_W-1:0] y);
    int dd;
    dd = int'(x) - int'(y);
    return dd * dd;
  endfunction

  function automatic nearest_t search_palette(input logic [npcs_pkg::WORD_W-1:0] pix);
    int unsigned n;
    int unsigned d;
    int unsigned best;
    logic [npcs_pkg::WORD_W-1:0] e;
    nearest_t res;
    n = searched(mdl_size);
    best = 32'hFFFF_FFFF;
    res.idx = '0;
    for (int j = 0; j < n; j++) begin
      e = mdl_pal[j];
      d = sq_diff(pix[7:0], e[7:0]) + sq_diff(pix[15:8], e[15:8])
        + sq_diff(pix[23:16], e[23:16]) + sq_diff(pix[31:24], e[31:24]);
      if (d <= best) begin
        best = d;
        res.idx = npcs_pkg::SLOT_W'(j);
      end
    end
    res.distance = npcs_pkg::DIST_W'(best);
    return res;
  endfunction

  // Input acceptance feeds the predictor; accepted results are checked in order.
  always @(posedge clk_i) begin : scoreboard
    nearest_t want;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (nearest_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result index %0d distance %0d",
                               palette_index_o, best_distance_o));
      end else begin
        want = nearest_q.pop_front();
        if (palette_index_o !== want.idx)
          log_mismatch($sformatf("palette_index %0d, expected %0d", palette_index_o, want.idx));
        if (best_distance_o !== want.distance)
          log_mismatch($sformatf("best_distance %0d, expected %0d", best_distance_o,
                                 want.distance));
      end
    end
    if (in_fire) begin
      if (npcs_pkg::req_e'(req_type_i) == npcs_pkg::REQ_LOAD)
        mdl_pal[entry_index_i] = {alpha_i, blue_i, green_i, red_i};
      else
        nearest_q.push_back(search_palette({alpha_i, blue_i, green_i, red_i}));
    end
  end

  always @(negedge clk_i) begin : driver
    color_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= nxt.kind;
        entry_index_i <= nxt.slot;
        red_i         <= nxt.color[7:0];
        green_i       <= nxt.color[15:8];
        blue_i        <= nxt.color[23:16];
        alpha_i       <= nxt.color[31:24];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [npcs_pkg::CHAN_W-1:0] pick_chan();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return npcs_pkg::CHAN_W'(64 * $urandom_range(1, 3));
      default: return npcs_pkg::CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [npcs_pkg::WORD_W-1:0] pick_color();
    return {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
  endfunction

  task automatic queue_load(input int slot, input logic [npcs_pkg::WORD_W-1:0] color);
    color_req_t r;
    r.kind  = npcs_pkg::REQ_LOAD;
    r.slot  = npcs_pkg::SLOT_W'(slot);
    r.color = color;
    plan_pal[slot] = color;
    req_q.push_back(r);
  endtask

  task automatic queue_pixel(input logic [npcs_pkg::WORD_W-1:0] color);
    color_req_t r;
    r.kind  = npcs_pkg::REQ_PIXEL;
    r.slot  = npcs_pkg::SLOT_W'($urandom_range(255));
    r.color = color;
    req_q.push_back(r);
  endtask

  task automatic wait_quiet();
    while (req_q.size() != 0 || in_valid_i || nearest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Waits for the block to go idle, sets the idling mix, then writes the palette size.
  task automatic begin_phase(input logic [npcs_pkg::SIZE_W-1:0] size);
    wait_quiet();
    if (phase_cnt < 8) begin
      send_idle_pct = 36;
      recv_idle_pct = 52;
    end else if (phase_cnt < 15) begin
      send_idle_pct = 52;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    phase_cnt++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mdl_size = size;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [npcs_pkg::SIZE_W-1:0] sizes[18];
    logic [npcs_pkg::WORD_W-1:0] word;
    int unsigned n;
    int count;
    sizes = '{9'd8, 9'd1, 9'd511, 9'd12, 9'd256, 9'd3, 9'd0, 9'd40, 9'd5,
              9'd300, 9'd16, 9'd2, 9'd255, 9'd7, 9'd64, 9'd10, 9'd257, 9'd6};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Size zero searches entry 0 only; the largest distance shows up here.
    begin_phase(9'd0);
    queue_load(0, 32'h0000_0000);
    queue_load(255, 32'hFFFF_FFFF);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'h0000_0000);

    // Equal distances to black and white must pick the higher index.
    begin_phase(9'd2);
    queue_load(1, 32'hFFFF_FFFF);
    queue_pixel(32'h00FF_00FF);
    queue_pixel(32'hFF00_FF00);
    queue_pixel(32'h7F80_7F80);

    begin_phase(9'd4);
    queue_load(2, 32'h281E_140A);
    queue_load(3, 32'h281E_140A);
    queue_pixel(32'h281E_140A);
    queue_pixel(32'h291F_150B);
    queue_pixel(32'h0100_0000);
    queue_pixel(32'h1932_64C8);
    queue_load(2, 32'h2A20_160C);
    queue_pixel(32'h2A20_160C);
    queue_pixel(32'h8080_8080);

    // Fill the whole palette so every later size is legal.
    begin_phase(9'd16);
    for (int s = 0; s < npcs_pkg::PALETTE_ENTRIES; s++) begin
      queue_load(s, pick_color());
      if (s >= 15 && $urandom_range(99) < 20) queue_pixel(pick_color());
    end

    for (int i = 0; i < 18; i++) begin
      begin_phase(sizes[i]);
      n = searched(sizes[i]);
      count = (n > 64) ? 12 : 40;
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(99) < 70) queue_load($urandom_range(n - 1), pick_color());
          else queue_load($urandom_range(255), pick_color());
        end else if ($urandom_range(3) == 0) begin
          word = plan_pal[$urandom_range(n - 1)];
          if ($urandom_range(1) == 1) word = word ^ (32'h1 << (8 * $urandom_range(3)));
          queue_pixel(word);
        end else begin
          queue_pixel(pick_color());
        end
      end
      if (phase_cnt == 17) hold_req = ~hold_req;
    end

    wait_quiet();
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
